// ----- design/tgi_pkg.sv -----
// ----------------------------------------------------------------------------
// tgi_pkg: shared types and constants of the triangular grid interpolator
// Beat layouts of both channels, request codes, sequencer states and the
// fixed widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tgi_pkg;

  // Widths fixed by the field formats.
  localparam int VAL_W       = 32;   // signed fixed-point values
  localparam int DIFF_W      = 33;   // difference of two values
  localparam int CNT_W       = 7;    // line count registers
  localparam int IDX_W       = 6;    // index fields of a write beat
  localparam int RATIO_W     = 31;   // saturated ratio, +-2^29
  localparam int RATIO_SHIFT = 29;   // ratio limit is 2^RATIO_SHIFT
  localparam int LO_W        = 17;   // low slice of a split multiplier operand
  localparam int HI_W        = DIFF_W - LO_W;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic CFG_X_COUNT = 1'b0;
  localparam logic CFG_V_COUNT = 1'b1;

  // Last step of the corner fetch sequence.
  localparam logic [2:0] FETCH_LAST = 3'd4;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_X_LINE = 2'd0,
    REQ_V_LINE = 2'd1,
    REQ_TABLE  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DIV_X,
    ST_DIV_V,
    ST_MUL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        x_index;
    logic [IDX_W-1:0]        v_index;
    logic signed [VAL_W-1:0] write_value;
    logic signed [VAL_W-1:0] query_x;
    logic signed [VAL_W-1:0] query_v;
    logic                    query_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic                    out_of_grid;
    logic                    result_last;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/tgi_ram.sv -----
// ----------------------------------------------------------------------------
// tgi_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/tgi_div.sv -----
// ----------------------------------------------------------------------------
// tgi_div: saturating fixed-point ratio divider
// Computes num * 2^FRAC_BITS / den truncated toward zero and saturated to
// +-2^29 (zero for a zero divisor), one quotient bit per cycle after an overflow check on start.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_div
  import tgi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [DIFF_W-1:0]   num,
  input  wire logic signed [DIFF_W-1:0]   den,
  output logic                            done,
  output logic signed [RATIO_W-1:0]       ratio
);

  localparam int RW = DIFF_W + RATIO_SHIFT + 2;
  localparam int IW = RATIO_SHIFT + 1;
  localparam int CW = $clog2(IW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] ds;
  logic [IW-1:0] q;
  logic          neg;
  logic          dz;
  logic          ovf;

  logic [DIFF_W-1:0] num_mag;
  logic [DIFF_W-1:0] den_mag;
  logic [RW-1:0]     rem_init;
  logic              step_ge;
  logic [IW-1:0]     limit;
  logic [IW-1:0]     mag;

  // Operand magnitudes and the scaled dividend.
  assign num_mag  = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
  assign den_mag  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
  assign rem_init = RW'(num_mag) << FRAC_BITS;
  assign step_ge  = rem >= ds;

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= rem_init;
        ds   <= RW'(den_mag) << RATIO_SHIFT;
        q    <= '0;
        neg  <= num[DIFF_W-1] ^ den[DIFF_W-1];
        dz   <= (den == '0);
        ovf  <= rem_init >= (RW'(den_mag) << (RATIO_SHIFT + 1));
      end else if (busy) begin
        if (step_ge) begin
          rem <= rem - ds;
        end
        q   <= {q[IW-2:0], step_ge};
        ds  <= ds >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(IW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate and apply the sign.
  assign limit = IW'(1) << RATIO_SHIFT;
  assign mag   = (ovf || (q > limit)) ? limit : q;

  always_comb begin
    if (dz) begin
      ratio = '0;
    end else if (neg) begin
      ratio = -RATIO_W'(mag);
    end else begin
      ratio = RATIO_W'(mag);
    end
  end

endmodule

`default_nettype wire

// ----- design/triangular_grid_interpolator_unit.sv -----
// Operation: a grid or table write beat goes straight into its memory. A query
// runs through grid search and corner fetch, two divisions in the shared ratio
// divider, the split multiplier and a summing state; one query is in work at a
// time.
// Reset: synchronous, clears the sequencer and output valid and sets both line
// counts to 64. Grid and table memories are undefined until written.
// ----------------------------------------------------------------------------
// triangular_grid_interpolator_unit: 2-D piecewise linear interpolation
// Grid lines and function values live in RAMs; a sequencer scans both axes,
// fetches the cell corners, divides, blends on the diagonal and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module triangular_grid_interpolator_unit
  import tgi_pkg::*;
#(
  parameter int MAX_X_LINES = 64,
  parameter int MAX_V_LINES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int XAW    = $clog2(MAX_X_LINES);
  localparam int VAW    = $clog2(MAX_V_LINES);
  localparam int TDEPTH = MAX_X_LINES * MAX_V_LINES;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int MAXL   = (MAX_X_LINES > MAX_V_LINES) ? MAX_X_LINES : MAX_V_LINES;
  localparam int KW     = $clog2(MAXL + 1);

  state_t state, state_next;

  logic [CNT_W-1:0] x_count;
  logic [CNT_W-1:0] v_count;
  logic [KW-1:0]    nx;
  logic [KW-1:0]    nv;

  logic in_acc;
  logic out_load;

  // Query registers.
  logic signed [VAL_W-1:0] qx, qv;
  logic                    q_last;
  logic                    oog;
  logic [KW-1:0]           k;
  logic [KW-1:0]           k_inc;
  logic                    xd, vd;
  logic [XAW-1:0]          cx;
  logic [VAW-1:0]          cv;
  logic [2:0]              j;
  logic signed [VAL_W-1:0] x0, x1, v0, v1;
  logic signed [VAL_W-1:0] f00, f10, f01, f11;
  logic signed [RATIO_W-1:0] tx, tv;
  logic [1:0]              m;
  logic                    ph;
  logic signed [PROD_W-1:0] acc, p0, s1, s2;
  logic                    ge;

  // Memory ports.
  logic           x_we, v_we, t_we;
  logic [XAW-1:0] x_waddr, x_raddr;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic signed [VAL_W-1:0] x_rd, v_rd, t_rd;

  // Scan decisions.
  logic           x_fin, x_clamp, v_fin, v_clamp;
  logic [XAW-1:0] x_cell_n;
  logic [VAW-1:0] v_cell_n;

  // Divider and multiplier.
  logic                      div_start, div_done, div_use_v;
  logic signed [DIFF_W-1:0]  div_num, div_den;
  logic signed [RATIO_W-1:0] div_ratio;
  logic signed [DIFF_W-1:0]  dx_num, dx_den, dv_num, dv_den;
  logic signed [DIFF_W-1:0]  ma, mb;
  logic signed [HI_W-1:0]    mb_hi;
  logic signed [DIFF_W+HI_W-1:0] pp_hi;
  logic signed [DIFF_W+LO_W:0]   pp_lo;
  logic signed [PROD_W-1:0]  full;
  logic signed [SUM_W-1:0]   sum;
  logic signed [VAL_W-1:0]   sat;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= COUNT_RESET;
      v_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_COUNT: x_count <= cfg_data;
        CFG_V_COUNT: v_count <= cfg_data;
      endcase
    end
  end

  // Effective line counts, clamped to two and to the memory depth.
  always_comb begin
    if (x_count < CNT_W'(2)) begin
      nx = KW'(2);
    end else if (int'(x_count) > MAX_X_LINES) begin
      nx = KW'(MAX_X_LINES);
    end else begin
      nx = KW'(x_count);
    end
    if (v_count < CNT_W'(2)) begin
      nv = KW'(2);
    end else if (int'(v_count) > MAX_V_LINES) begin
      nv = KW'(MAX_V_LINES);
    end else begin
      nv = KW'(v_count);
    end
  end

  // Write beats go straight into the memories.
  assign x_we = in_acc && (in_data.req_type == REQ_X_LINE) &&
                (int'(in_data.x_index) < MAX_X_LINES);
  assign v_we = in_acc && (in_data.req_type == REQ_V_LINE) &&
                (int'(in_data.v_index) < MAX_V_LINES);
  assign t_we = in_acc && (in_data.req_type == REQ_TABLE) &&
                (int'(in_data.x_index) < MAX_X_LINES) &&
                (int'(in_data.v_index) < MAX_V_LINES);
  assign x_waddr = XAW'(in_data.x_index);
  assign v_waddr = VAW'(in_data.v_index);
  assign t_waddr = TAW'(TAW'(in_data.x_index) * TAW'(MAX_V_LINES) + TAW'(in_data.v_index));

  // Read addresses: line 0 on accept, the next line while scanning,
  // then the cell corners.
  assign k_inc = k + 1'b1;

  always_comb begin
    x_raddr = '0;
    v_raddr = '0;
    t_raddr = '0;
    if (state == ST_SCAN) begin
      x_raddr = XAW'(k_inc);
      v_raddr = VAW'(k_inc);
    end else if (state == ST_FETCH) begin
      x_raddr = cx + XAW'(j != 3'd0);
      v_raddr = cv + VAW'(j != 3'd0);
      t_raddr = TAW'(TAW'(cx + XAW'(j[0])) * TAW'(MAX_V_LINES) + TAW'(cv + VAW'(j[1])));
    end
  end

  tgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_X_LINES)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(in_data.write_value),
    .raddr(x_raddr), .rdata(x_rd)
  );

  tgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_V_LINES)) u_v_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(in_data.write_value),
    .raddr(v_raddr), .rdata(v_rd)
  );

  tgi_ram #(.WIDTH(VAL_W), .DEPTH(TDEPTH)) u_t_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(in_data.write_value),
    .raddr(t_raddr), .rdata(t_rd)
  );

  // Search step on each axis: line k is on the read data this cycle.
  always_comb begin
    if (k_inc < nx) begin
      x_fin    = x_rd > qx;
      x_clamp  = x_fin && (k == '0);
      x_cell_n = (k == '0) ? '0 : XAW'(k - 1'b1);
    end else begin
      x_fin    = 1'b1;
      x_clamp  = qx >= x_rd;
      x_cell_n = XAW'(nx - KW'(2));
    end
    if (k_inc < nv) begin
      v_fin    = v_rd > qv;
      v_clamp  = v_fin && (k == '0);
      v_cell_n = (k == '0) ? '0 : VAW'(k - 1'b1);
    end else begin
      v_fin    = 1'b1;
      v_clamp  = qv >= v_rd;
      v_cell_n = VAW'(nv - KW'(2));
    end
  end

  // Coordinate offsets and cell spacings.
  assign dx_num = DIFF_W'(qx) - DIFF_W'(x0);
  assign dx_den = DIFF_W'(x1) - DIFF_W'(x0);
  assign dv_num = DIFF_W'(qv) - DIFF_W'(v0);
  assign dv_den = DIFF_W'(v1) - DIFF_W'(v0);

  // Shared ratio divider, x axis first.
  assign div_num = div_use_v ? dv_num : dx_num;
  assign div_den = div_use_v ? dv_den : dx_den;

  tgi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .ratio(div_ratio)
  );

  // Multiplier operands: the two diagonal cross products, then the blends.
  always_comb begin
    unique case (m)
      2'd0: begin
        ma = dv_num;
        mb = dx_den;
      end
      2'd1: begin
        ma = dv_den;
        mb = dx_num;
      end
      2'd2: begin
        ma = DIFF_W'(tx);
        mb = ge ? (DIFF_W'(f11) - DIFF_W'(f01)) : (DIFF_W'(f10) - DIFF_W'(f00));
      end
      default: begin
        ma = DIFF_W'(tv);
        mb = ge ? (DIFF_W'(f01) - DIFF_W'(f00)) : (DIFF_W'(f11) - DIFF_W'(f10));
      end
    endcase
  end

  // Split multiply: high slice first, low slice added the next cycle.
  assign mb_hi = mb[DIFF_W-1:LO_W];
  assign pp_hi = ma * mb_hi;
  assign pp_lo = ma * $signed({1'b0, mb[LO_W-1:0]});
  assign full  = acc + PROD_W'(pp_lo);

  // Blend sum and saturation.
  assign sum = SUM_W'(f00) + SUM_W'(s1) + SUM_W'(s2);

  always_comb begin
    if (sum > SUM_W'($signed(32'h7fffffff))) begin
      sat = $signed(32'h7fffffff);
    end else if (sum < SUM_W'($signed(32'h80000000))) begin
      sat = $signed(32'h80000000);
    end else begin
      sat = VAL_W'(sum);
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_use_v  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((xd || x_fin) && (vd || v_fin)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (j == FETCH_LAST) begin
          div_start  = 1'b1;
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        div_use_v = 1'b1;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if ((m == 2'd3) && ph) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Query datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        qx     <= in_data.query_x;
        qv     <= in_data.query_v;
        q_last <= in_data.query_last;
        oog    <= 1'b0;
        k      <= '0;
        xd     <= 1'b0;
        vd     <= 1'b0;
        j      <= '0;
      end
      ST_SCAN: begin
        k <= k_inc;
        if (!xd && x_fin) begin
          xd <= 1'b1;
          cx <= x_cell_n;
          if (x_clamp) begin
            qx  <= x_rd;
            oog <= 1'b1;
          end
        end
        if (!vd && v_fin) begin
          vd <= 1'b1;
          cv <= v_cell_n;
          if (v_clamp) begin
            qv  <= v_rd;
            oog <= 1'b1;
          end
        end
      end
      ST_FETCH: begin
        j <= j + 1'b1;
        if (j == 3'd1) begin
          x0  <= x_rd;
          v0  <= v_rd;
          f00 <= t_rd;
        end
        if (j == 3'd2) begin
          x1  <= x_rd;
          v1  <= v_rd;
          f10 <= t_rd;
        end
        if (j == 3'd3) begin
          f01 <= t_rd;
        end
        if (j == FETCH_LAST) begin
          f11 <= t_rd;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          tx <= div_ratio;
        end
      end
      ST_DIV_V: begin
        m  <= '0;
        ph <= 1'b0;
        if (div_done) begin
          tv <= div_ratio;
        end
      end
      ST_MUL: begin
        ph <= !ph;
        if (!ph) begin
          acc <= PROD_W'(pp_hi) <<< LO_W;
        end else begin
          m <= m + 1'b1;
          unique case (m)
            2'd0: p0 <= full;
            2'd1: ge <= p0 >= full;
            2'd2: s1 <= full >>> FRAC_BITS;
            default: s2 <= full >>> FRAC_BITS;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.interp_value <= sat;
      out_data.out_of_grid  <= oog;
      out_data.result_last  <= q_last;
    end
  end

endmodule

`default_nettype wire
